@@ design/alu8f_pkg.sv @@
// Shared types, operation codes and flag bit positions for the 8-bit ALU.
package alu8f_pkg;

	// Operation codes; codes 14 and 15 are unused and pass the request through
	typedef enum logic [3:0] {
		OP_ADD = 4'd0,
		OP_ADC = 4'd1,
		OP_SUB = 4'd2,
		OP_SBC = 4'd3,
		OP_AND = 4'd4,
		OP_XOR = 4'd5,
		OP_OR  = 4'd6,
		OP_CP  = 4'd7,
		OP_INC = 4'd8,
		OP_DEC = 4'd9,
		OP_DAA = 4'd10,
		OP_CPL = 4'd11,
		OP_SCF = 4'd12,
		OP_CCF = 4'd13
	} op_t;

	// Unused operation codes
	localparam logic [3:0] OP_UNUSED_LO = 4'd14;
	localparam logic [3:0] OP_UNUSED_HI = 4'd15;

	// Flag byte bit positions: S Z Y H X PV N C
	localparam int FLAG_S  = 7;
	localparam int FLAG_Z  = 6;
	localparam int FLAG_Y  = 5;
	localparam int FLAG_H  = 4;
	localparam int FLAG_X  = 3;
	localparam int FLAG_PV = 2;
	localparam int FLAG_N  = 1;
	localparam int FLAG_C  = 0;

	// DAA thresholds and correction values
	localparam logic [7:0] DAA_HI_LIMIT = 8'h99;
	localparam logic [3:0] DAA_LO_LIMIT = 4'h9;
	localparam logic [7:0] DAA_CORR_HI  = 8'h60;
	localparam logic [7:0] DAA_CORR_LO  = 8'h06;

	typedef struct packed {
		logic [3:0] operation;
		logic [7:0] acc_in;
		logic [7:0] operand;
		logic [7:0] flags_in;
	} req_t;

	typedef struct packed {
		logic [7:0] result;
		logic [7:0] flags_out;
	} rsp_t;

endpackage

@@ design/alu8f_req_if.sv @@
// Request channel: operation, accumulator, operand and incoming flags.
interface alu8f_req_if;
	logic       valid;
	logic       ready;
	logic [3:0] operation;
	logic [7:0] acc_in;
	logic [7:0] operand;
	logic [7:0] flags_in;

	modport source (output valid, output operation, output acc_in, output operand,
		output flags_in, input ready);
	modport sink (input valid, input operation, input acc_in, input operand,
		input flags_in, output ready);
endinterface

@@ design/alu8f_rsp_if.sv @@
// Response channel: destination value and new flags.
interface alu8f_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] result;
	logic [7:0] flags_out;

	modport source (output valid, output result, output flags_out, input ready);
	modport sink (input valid, input result, input flags_out, output ready);
endinterface

@@ design/alu8f_exec.sv @@
// Combinational ALU datapath: shared 8-bit adder, logic unit, DAA and flag assembly.
module alu8f_exec (
	input  alu8f_pkg::req_t req,
	output alu8f_pkg::rsp_t rsp
);

	alu8f_pkg::op_t op;
	logic [7:0] acc;
	logic [7:0] opd;
	logic [7:0] fi;
	logic       cf;

	// adder signals
	logic [7:0] add_a;
	logic [7:0] add_b;
	logic       add_cin;
	logic       is_sub;
	logic [8:0] sum9;
	logic [4:0] lo5;
	logic [7:0] ar;
	logic [7:0] af;

	// logic unit signals
	logic [7:0] lr;
	logic [7:0] lf;

	// decimal adjust signals
	logic       daa_hi;
	logic       daa_lo;
	logic [7:0] corr;
	logic [7:0] dr;
	logic [7:0] df;

	assign op  = alu8f_pkg::op_t'(req.operation);
	assign acc = req.acc_in;
	assign opd = req.operand;
	assign fi  = req.flags_in;
	assign cf  = fi[alu8f_pkg::FLAG_C];

	// Select adder operands; subtraction adds the inverted operand
	always_comb begin
		add_a   = acc;
		add_b   = opd;
		add_cin = 1'b0;
		is_sub  = 1'b0;
		case (op) inside
			alu8f_pkg::OP_ADC: begin
				add_cin = cf;
			end
			alu8f_pkg::OP_SUB, alu8f_pkg::OP_CP: begin
				add_b   = ~opd;
				add_cin = 1'b1;
				is_sub  = 1'b1;
			end
			alu8f_pkg::OP_SBC: begin
				add_b   = ~opd;
				add_cin = ~cf;
				is_sub  = 1'b1;
			end
			alu8f_pkg::OP_INC: begin
				add_a   = opd;
				add_b   = 8'h01;
			end
			alu8f_pkg::OP_DEC: begin
				add_a   = opd;
				add_b   = 8'hFE;
				add_cin = 1'b1;
				is_sub  = 1'b1;
			end
			default: begin
				add_a   = acc;
			end
		endcase
	end

	// Add and derive arithmetic flags; borrows are inverted carries
	always_comb begin
		sum9 = {1'b0, add_a} + {1'b0, add_b} + {8'b0, add_cin};
		lo5  = {1'b0, add_a[3:0]} + {1'b0, add_b[3:0]} + {4'b0, add_cin};
		ar   = sum9[7:0];
		af   = {ar[7], (ar == 8'h00), ar[5], lo5[4] ^ is_sub, ar[3],
			(add_a[7] ^ ar[7]) & (add_b[7] ^ ar[7]), is_sub, sum9[8] ^ is_sub};
	end

	// Logic unit; H set only for and
	always_comb begin
		case (op) inside
			alu8f_pkg::OP_AND: lr = acc & opd;
			alu8f_pkg::OP_XOR: lr = acc ^ opd;
			default:           lr = acc | opd;
		endcase
		lf = {lr[7], (lr == 8'h00), lr[5], (op == alu8f_pkg::OP_AND), lr[3], ~^lr,
			1'b0, 1'b0};
	end

	// Decimal adjust: correction added or subtracted by N
	always_comb begin
		daa_hi = (acc > alu8f_pkg::DAA_HI_LIMIT) || cf;
		daa_lo = (acc[3:0] > alu8f_pkg::DAA_LO_LIMIT) || fi[alu8f_pkg::FLAG_H];
		corr   = (daa_hi ? alu8f_pkg::DAA_CORR_HI : 8'h00)
			| (daa_lo ? alu8f_pkg::DAA_CORR_LO : 8'h00);
		dr     = fi[alu8f_pkg::FLAG_N] ? (acc - corr) : (acc + corr);
		df     = {dr[7], (dr == 8'h00), dr[5], acc[4] ^ dr[4], dr[3], ~^dr,
			fi[alu8f_pkg::FLAG_N], daa_hi};
	end

	// Pick destination value and flags per operation
	always_comb begin
		unique case (op)
			alu8f_pkg::OP_ADD, alu8f_pkg::OP_ADC,
			alu8f_pkg::OP_SUB, alu8f_pkg::OP_SBC: begin
				rsp.result    = ar;
				rsp.flags_out = af;
			end
			alu8f_pkg::OP_AND, alu8f_pkg::OP_XOR, alu8f_pkg::OP_OR: begin
				rsp.result    = lr;
				rsp.flags_out = lf;
			end
			alu8f_pkg::OP_CP: begin
				rsp.result    = acc;
				rsp.flags_out = {af[7:6], opd[5], af[4], opd[3], af[2:0]};
			end
			alu8f_pkg::OP_INC, alu8f_pkg::OP_DEC: begin
				rsp.result    = ar;
				rsp.flags_out = {af[7:1], cf};
			end
			alu8f_pkg::OP_DAA: begin
				rsp.result    = dr;
				rsp.flags_out = df;
			end
			alu8f_pkg::OP_CPL: begin
				rsp.result    = ~acc;
				rsp.flags_out = {fi[7:6], ~acc[5], 1'b1, ~acc[3], fi[2], 1'b1, cf};
			end
			alu8f_pkg::OP_SCF: begin
				rsp.result    = acc;
				rsp.flags_out = {fi[7:6], acc[5], 1'b0, acc[3], fi[2], 1'b0, 1'b1};
			end
			alu8f_pkg::OP_CCF: begin
				rsp.result    = acc;
				rsp.flags_out = {fi[7:6], acc[5], cf, acc[3], fi[2], 1'b0, ~cf};
			end
			default: begin
				rsp.result    = acc;
				rsp.flags_out = fi;
			end
		endcase
	end

endmodule

@@ design/eight_bit_alu_with_flags_top.sv @@
// Top level of the 8-bit ALU: input register, datapath and result register.
//
//  channel | dir | payload                                  | handshake
//  req     | in  | operation, acc_in, operand, flags_in      | valid/ready
//  rsp     | out | result, flags_out                        | valid/ready
//
// Each request passes through the input register and then the result
// register; one request is accepted per cycle unless a full pipe is stalled by rsp.
// The datapath between the two registers is one 8-bit add plus flag logic.
// Reset clears both valid bits; payload registers are not reset.
// A stalled response holds the result register; the input register still
// advances into it as soon as it drains, so a full pipe stalls req.
module eight_bit_alu_with_flags_top (
	input  logic              clk,
	input  logic              arst_n,
	alu8f_req_if.sink         req,
	alu8f_rsp_if.source       rsp
);

	logic              valid_s1;
	alu8f_pkg::req_t   req_s1;
	logic              valid_s2;
	alu8f_pkg::rsp_t   rsp_s2;
	alu8f_pkg::rsp_t   exec_rsp;
	logic              adv_s2;
	logic              adv_s1;

	// Advance a stage when it is empty or its downstream moves
	assign adv_s2    = !valid_s2 || rsp.ready;
	assign adv_s1    = !valid_s1 || adv_s2;
	assign req.ready = adv_s1;

	// Capture the request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && req.valid) begin
			req_s1 <= '{operation: req.operation, acc_in: req.acc_in,
				operand: req.operand, flags_in: req.flags_in};
		end
	end

	alu8f_exec u_exec (
		.req (req_s1),
		.rsp (exec_rsp)
	);

	// Hold the result until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			rsp_s2 <= exec_rsp;
		end
	end

	assign rsp.valid     = valid_s2;
	assign rsp.result    = rsp_s2.result;
	assign rsp.flags_out = rsp_s2.flags_out;

	// An accepted request lands in the input register
	a_capture: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> valid_s1)
		else $error("accepted request not captured");

	// A computed result is presented on the next cycle
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && adv_s2 |=> rsp.valid)
		else $error("result lost between stages");

	// An empty result register never backpressures the request side
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp.valid |-> req.ready)
		else $error("request stalled with empty output");

	// An unused code passes the accumulator and flags through
	a_unused: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && adv_s2 && (req_s1.operation == alu8f_pkg::OP_UNUSED_LO ||
			req_s1.operation == alu8f_pkg::OP_UNUSED_HI)
		|=> rsp.result == $past(req_s1.acc_in) && rsp.flags_out == $past(req_s1.flags_in))
		else $error("unused operation altered state");

endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for the 8-bit ALU with flags: random and directed requests.
module tb_top;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int         CYCLE_LIMIT   = 200000;
	localparam int         RANDOM_ITEMS  = 1050;
	localparam int         DRAIN_EVERY   = 350;
	localparam int         SETTLE_CYCLES = 8;

	typedef enum {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_PERIODIC} stall_mode_t;

	typedef struct {
		alu8f_pkg::req_t rq;
		bit              drain_first;
	} stim_t;

	logic clk;
	logic arst_n;

	alu8f_req_if req_ch ();
	alu8f_rsp_if rsp_ch ();

	eight_bit_alu_with_flags_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	stim_t           pending_reqs[$];
	alu8f_pkg::rsp_t expected_rsps[$];
	int              fail_count = 0;
	int              cycle_count = 0;

	// S, Z, Y and X of an 8-bit value
	function automatic logic [7:0] sign_zero_xy(logic [7:0] r);
		logic [7:0] f;
		f = '0;
		f[alu8f_pkg::FLAG_S] = r[7];
		f[alu8f_pkg::FLAG_Z] = (r == 8'h00);
		f[alu8f_pkg::FLAG_Y] = r[5];
		f[alu8f_pkg::FLAG_X] = r[3];
		return f;
	endfunction

	// S, Z, Y, X and even parity of a logic result
	function automatic logic [7:0] logic_flags(logic [7:0] r);
		logic [7:0] f;
		f = sign_zero_xy(r);
		f[alu8f_pkg::FLAG_PV] = ~^r;
		return f;
	endfunction

	// 8-bit add with carry in, arithmetic flags
	function automatic void add8(input logic [7:0] a, input logic [7:0] b, input logic cin,
		output logic [7:0] r, output logic [7:0] f);
		logic [4:0] lo;
		logic [8:0] sum;
		lo = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin};
		sum = {1'b0, a} + {1'b0, b} + {8'd0, cin};
		r = sum[7:0];
		f = sign_zero_xy(r);
		f[alu8f_pkg::FLAG_H] = lo[4];
		f[alu8f_pkg::FLAG_C] = sum[8];
		f[alu8f_pkg::FLAG_PV] = (a[7] ^ r[7]) & (b[7] ^ r[7]);
	endfunction

	// 8-bit subtract with borrow in; H and C become borrows, N set
	function automatic void sub8(input logic [7:0] a, input logic [7:0] b, input logic bin,
		output logic [7:0] r, output logic [7:0] f);
		add8(a, ~b, ~bin, r, f);
		f[alu8f_pkg::FLAG_H] = ~f[alu8f_pkg::FLAG_H];
		f[alu8f_pkg::FLAG_C] = ~f[alu8f_pkg::FLAG_C];
		f[alu8f_pkg::FLAG_N] = 1'b1;
	endfunction

	// Compute the response that one request must produce
	function automatic alu8f_pkg::rsp_t alu_predict(alu8f_pkg::req_t rq);
		logic [7:0]      a, v, fi, r, f, corr;
		logic            cf, nc;
		alu8f_pkg::rsp_t out;
		a = rq.acc_in;
		v = rq.operand;
		fi = rq.flags_in;
		cf = fi[alu8f_pkg::FLAG_C];
		r = a;
		f = fi;
		case (rq.operation)
			alu8f_pkg::OP_ADD: add8(a, v, 1'b0, r, f);
			alu8f_pkg::OP_ADC: add8(a, v, cf, r, f);
			alu8f_pkg::OP_SUB: sub8(a, v, 1'b0, r, f);
			alu8f_pkg::OP_SBC: sub8(a, v, cf, r, f);
			alu8f_pkg::OP_AND: begin
				r = a & v;
				f = logic_flags(r);
				f[alu8f_pkg::FLAG_H] = 1'b1;
			end
			alu8f_pkg::OP_XOR: begin
				r = a ^ v;
				f = logic_flags(r);
			end
			alu8f_pkg::OP_OR: begin
				r = a | v;
				f = logic_flags(r);
			end
			alu8f_pkg::OP_CP: begin
				sub8(a, v, 1'b0, r, f);
				f[alu8f_pkg::FLAG_Y] = v[5];
				f[alu8f_pkg::FLAG_X] = v[3];
				r = a;
			end
			alu8f_pkg::OP_INC: begin
				add8(v, 8'h01, 1'b0, r, f);
				f[alu8f_pkg::FLAG_C] = cf;
			end
			alu8f_pkg::OP_DEC: begin
				sub8(v, 8'h01, 1'b0, r, f);
				f[alu8f_pkg::FLAG_C] = cf;
			end
			alu8f_pkg::OP_DAA: begin
				corr = '0;
				nc = 1'b0;
				if (a > alu8f_pkg::DAA_HI_LIMIT || cf) begin
					corr = alu8f_pkg::DAA_CORR_HI;
					nc = 1'b1;
				end
				if (a[3:0] > alu8f_pkg::DAA_LO_LIMIT || fi[alu8f_pkg::FLAG_H])
					corr = corr + alu8f_pkg::DAA_CORR_LO;
				r = fi[alu8f_pkg::FLAG_N] ? a - corr : a + corr;
				f = logic_flags(r);
				f[alu8f_pkg::FLAG_C] = nc;
				f[alu8f_pkg::FLAG_N] = fi[alu8f_pkg::FLAG_N];
				f[alu8f_pkg::FLAG_H] = a[4] ^ r[4];
			end
			alu8f_pkg::OP_CPL: begin
				r = ~a;
				f = '0;
				f[alu8f_pkg::FLAG_S] = fi[alu8f_pkg::FLAG_S];
				f[alu8f_pkg::FLAG_Z] = fi[alu8f_pkg::FLAG_Z];
				f[alu8f_pkg::FLAG_PV] = fi[alu8f_pkg::FLAG_PV];
				f[alu8f_pkg::FLAG_C] = fi[alu8f_pkg::FLAG_C];
				f[alu8f_pkg::FLAG_H] = 1'b1;
				f[alu8f_pkg::FLAG_N] = 1'b1;
				f[alu8f_pkg::FLAG_Y] = r[5];
				f[alu8f_pkg::FLAG_X] = r[3];
			end
			alu8f_pkg::OP_SCF, alu8f_pkg::OP_CCF: begin
				r = a;
				f = '0;
				f[alu8f_pkg::FLAG_S] = fi[alu8f_pkg::FLAG_S];
				f[alu8f_pkg::FLAG_Z] = fi[alu8f_pkg::FLAG_Z];
				f[alu8f_pkg::FLAG_PV] = fi[alu8f_pkg::FLAG_PV];
				f[alu8f_pkg::FLAG_Y] = a[5];
				f[alu8f_pkg::FLAG_X] = a[3];
				if (rq.operation == alu8f_pkg::OP_SCF) begin
					f[alu8f_pkg::FLAG_C] = 1'b1;
				end else begin
					f[alu8f_pkg::FLAG_H] = cf;
					f[alu8f_pkg::FLAG_C] = ~cf;
				end
			end
			default: begin
				r = a;
				f = fi;
			end
		endcase
		out.result = r;
		out.flags_out = f;
		return out;
	endfunction

	// Queue one request for the driver
	task automatic push_req(logic [3:0] op, logic [7:0] a, logic [7:0] v, logic [7:0] fi,
		bit drain_first);
		stim_t s;
		s.rq.operation = op;
		s.rq.acc_in = a;
		s.rq.operand = v;
		s.rq.flags_in = fi;
		s.drain_first = drain_first;
		pending_reqs.push_back(s);
	endtask

	// Random byte, biased toward the boundary values
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 11))
			0: return 8'h00;
			1: return 8'hFF;
			2: return 8'h7F;
			3: return 8'h80;
			default: return 8'($urandom);
		endcase
	endfunction

	// Clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Cycle counter and timeout
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("eight_bit_alu_with_flags_top: mismatch");
			$finish;
		end
	end

	// Driver: bursts of requests with random gaps, optional drain before an item
	int gap_left = 0;
	int burst_left = 1;
	always @(posedge clk) begin : driver
		alu8f_pkg::req_t acc_rq;
		logic            next_valid;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else begin
			// record the request accepted at this edge
			if (req_ch.valid && req_ch.ready) begin
				acc_rq.operation = req_ch.operation;
				acc_rq.acc_in = req_ch.acc_in;
				acc_rq.operand = req_ch.operand;
				acc_rq.flags_in = req_ch.flags_in;
				expected_rsps.push_back(alu_predict(acc_rq));
			end
			// hold a request that is still waiting
			if (!(req_ch.valid && !req_ch.ready)) begin
				next_valid = 1'b0;
				if (gap_left != 0) begin
					gap_left = gap_left - 1;
				end else if (pending_reqs.size() != 0 &&
					!(pending_reqs[0].drain_first && expected_rsps.size() != 0)) begin
					req_ch.operation <= pending_reqs[0].rq.operation;
					req_ch.acc_in <= pending_reqs[0].rq.acc_in;
					req_ch.operand <= pending_reqs[0].rq.operand;
					req_ch.flags_in <= pending_reqs[0].rq.flags_in;
					void'(pending_reqs.pop_front());
					next_valid = 1'b1;
					burst_left = burst_left - 1;
					if (burst_left <= 0) begin
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
						burst_left = $urandom_range(1, 40);
					end
				end
				req_ch.valid <= next_valid;
			end
		end
	end

	// Monitor: compare each response with the oldest prediction, stall on a pattern
	stall_mode_t stall_mode = RDY_ALWAYS;
	int          mode_left = 0;
	logic [3:0]  stall_phase = '0;
	always @(posedge clk) begin : monitor
		alu8f_pkg::rsp_t want;
		logic            next_ready;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_rsps.size() == 0) begin
					$error("response with no request outstanding: result %02h flags_out %02h",
						rsp_ch.result, rsp_ch.flags_out);
					fail_count++;
				end else begin
					want = expected_rsps.pop_front();
					if (rsp_ch.result !== want.result) begin
						$error("result: expected %02h, actual %02h", want.result, rsp_ch.result);
						fail_count++;
					end
					if (rsp_ch.flags_out !== want.flags_out) begin
						$error("flags_out: expected %02h, actual %02h",
							want.flags_out, rsp_ch.flags_out);
						fail_count++;
					end
				end
			end
			// advance the stall pattern
			if (mode_left == 0) begin
				stall_mode = stall_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(16, 96);
			end else begin
				mode_left = mode_left - 1;
			end
			stall_phase = stall_phase + 4'd1;
			case (stall_mode)
				RDY_ALWAYS:   next_ready = 1'b1;
				RDY_COIN:     next_ready = 1'($urandom_range(0, 1));
				RDY_SPARSE:   next_ready = ($urandom_range(0, 4) == 0);
				default:      next_ready = stall_phase[2];
			endcase
			rsp_ch.ready <= next_ready;
		end
	end

	// Stimulus, reset and end of run
	initial begin
		req_ch.valid = 1'b0;
		req_ch.operation = '0;
		req_ch.acc_in = '0;
		req_ch.operand = '0;
		req_ch.flags_in = '0;
		rsp_ch.ready = 1'b0;
		arst_n = 1'b0;

		// directed: extremes and the corner cases of each operation
		push_req(alu8f_pkg::OP_ADD, 8'hFF, 8'h01, 8'h00, 1'b0);
		push_req(alu8f_pkg::OP_ADD, 8'h7F, 8'h01, 8'hFF, 1'b0);
		push_req(alu8f_pkg::OP_ADC, 8'hFF, 8'h00, 8'h01, 1'b0);
		push_req(alu8f_pkg::OP_ADC, 8'h0F, 8'h00, 8'hFE, 1'b0);
		push_req(alu8f_pkg::OP_SUB, 8'h00, 8'h01, 8'h00, 1'b0);
		push_req(alu8f_pkg::OP_SUB, 8'h80, 8'h01, 8'hFF, 1'b0);
		push_req(alu8f_pkg::OP_SBC, 8'h00, 8'hFF, 8'h01, 1'b0);
		push_req(alu8f_pkg::OP_SBC, 8'h10, 8'h00, 8'h00, 1'b0);
		push_req(alu8f_pkg::OP_AND, 8'hFF, 8'h00, 8'hFF, 1'b0);
		push_req(alu8f_pkg::OP_AND, 8'hFF, 8'hFF, 8'h00, 1'b0);
		push_req(alu8f_pkg::OP_XOR, 8'hAA, 8'h55, 8'h00, 1'b0);
		push_req(alu8f_pkg::OP_OR,  8'h00, 8'h00, 8'hFF, 1'b0);
		// compare takes Y and X from the operand
		push_req(alu8f_pkg::OP_CP,  8'h10, 8'h28, 8'h00, 1'b0);
		push_req(alu8f_pkg::OP_CP,  8'h55, 8'h55, 8'hFF, 1'b0);
		// increment and decrement keep carry; overflow at the signed boundary
		push_req(alu8f_pkg::OP_INC, 8'h00, 8'h7F, 8'h00, 1'b0);
		push_req(alu8f_pkg::OP_INC, 8'h12, 8'hFF, 8'h01, 1'b0);
		push_req(alu8f_pkg::OP_DEC, 8'h00, 8'h80, 8'h01, 1'b0);
		push_req(alu8f_pkg::OP_DEC, 8'hFF, 8'h00, 8'hFE, 1'b0);
		// decimal adjust: both nibbles high, subtract with half borrow, carry in
		push_req(alu8f_pkg::OP_DAA, 8'h9A, 8'h00, 8'h00, 1'b0);
		push_req(alu8f_pkg::OP_DAA, 8'h0F, 8'h00, 8'h12, 1'b0);
		push_req(alu8f_pkg::OP_DAA, 8'h00, 8'h00, 8'h01, 1'b0);
		push_req(alu8f_pkg::OP_CPL, 8'h5A, 8'h00, 8'hFF, 1'b0);
		push_req(alu8f_pkg::OP_SCF, 8'h28, 8'h00, 8'h10, 1'b0);
		push_req(alu8f_pkg::OP_CCF, 8'hD7, 8'h00, 8'h01, 1'b0);
		push_req(alu8f_pkg::OP_CCF, 8'h00, 8'hFF, 8'hFE, 1'b0);
		// unused codes pass the request through
		push_req(alu8f_pkg::OP_UNUSED_LO, 8'hA5, 8'h5A, 8'hFF, 1'b0);
		push_req(alu8f_pkg::OP_UNUSED_HI, 8'h3C, 8'hC3, 8'h00, 1'b0);

		// random: mostly defined operations, a few unused codes
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			push_req(($urandom_range(0, 19) == 0) ?
					4'($urandom_range(alu8f_pkg::OP_UNUSED_LO, alu8f_pkg::OP_UNUSED_HI)) :
					4'($urandom_range(alu8f_pkg::OP_ADD, alu8f_pkg::OP_CCF)),
				pick_byte(), pick_byte(), 8'($urandom), (i % DRAIN_EVERY) == 0);
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// wait for every request to be accepted, then for every response
		do @(posedge clk); while (pending_reqs.size() != 0 || req_ch.valid);
		while (expected_rsps.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (fail_count == 0) begin
			$display("eight_bit_alu_with_flags_top: match");
		end else begin
			$display("eight_bit_alu_with_flags_top: mismatch");
		end
		$finish;
	end

endmodule
